[hw/rtl/stffa_pkg.sv]
// Package for the first-fit slot allocator: request and result types,
// request and status codes, and default sizes. No dependencies.
`default_nettype none

package stffa_pkg;

    // Default table geometry.
    localparam int SLOTS_DEF       = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Field widths of the request and result transactions.
    localparam int REQ_W   = 3;
    localparam int IDX_F_W = 6;
    localparam int VAL_F_W = 32;
    localparam int LIM_F_W = 7;
    localparam int ST_W    = 2;
    localparam int CNT_F_W = 7;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_READ      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ADD       = 3'd3;
    localparam logic [REQ_W-1:0] REQ_ADD_RANGE = 3'd4;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD     = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [IDX_F_W-1:0] slot_index;
        logic [VAL_F_W-1:0] store_value;
        logic [IDX_F_W-1:0] range_first;
        logic [LIM_F_W-1:0] range_limit;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [IDX_F_W-1:0] slot_used;
        logic [VAL_F_W-1:0] read_value;
        logic [CNT_F_W-1:0] occupied_count;
    } t_res;

endpackage

`default_nettype wire

[hw/rtl/slot_table_first_free_allocator.sv]
// Top level of the first-fit slot allocator: occupancy bitmap, first-free
// search and read-modify-write control around one slot RAM.
// Depends on stffa_pkg and stffa_ram.
//
//   Channel   | Handshake            | Payload          | Direction
//   ----------+----------------------+------------------+----------
//   request   | start / busy         | i_req  (t_req)   | in
//   result    | o_done (one cycle)   | o_res  (t_res)   | out
//
// For each request, the accept cycle looks up the bitmap, finds the slot and
// issues the RAM read; the next cycle returns the result and writes the RAM.
// busy is high during that result cycle, so no new transaction can be
// accepted until the current result is out, as the RAM read is registered.
// Reset clears the bitmap and count at once; no clearing pass is needed, as
// a slot whose bitmap bit is clear reads as empty. The receiver cannot stall.
`default_nettype none

module slot_table_first_free_allocator #(
    parameter int SLOTS       = stffa_pkg::SLOTS_DEF,
    parameter int VALUE_WIDTH = stffa_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire stffa_pkg::t_req i_req,
    output logic                 o_done,
    output stffa_pkg::t_res      o_res
);

    import stffa_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RESP = 1'b1;

    logic                   r_state;
    logic [SLOTS-1:0]       r_bitmap;
    logic [SLOTS-1:0]       n_bitmap;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic [ST_W-1:0]        r_status;
    logic [ST_W-1:0]        n_status;
    logic [IDX_W-1:0]       r_used;
    logic [IDX_W-1:0]       n_used;
    logic                   r_was_occ;
    logic                   n_was_occ;
    logic                   r_we;
    logic                   n_we;
    logic [VALUE_WIDTH-1:0] r_wdata;

    logic                   accept;
    logic [VALUE_WIDTH-1:0] val;
    logic                   val_zero;
    logic [IDX_W-1:0]       idx;
    logic                   idx_bad;
    logic [31:0]            lo;
    logic [31:0]            hi;
    logic                   range_bad;
    logic [SLOTS-1:0]       cand;
    logic [IDX_W-1:0]       found;
    logic                   found_any;
    logic [VALUE_WIDTH-1:0] ram_q;

    assign accept = start && !busy;
    assign busy   = (r_state == S_RESP);
    assign o_done = (r_state == S_RESP);

    // Decode of the incoming request.
    assign val       = VALUE_WIDTH'(i_req.store_value);
    assign val_zero  = (val == '0);
    assign idx       = IDX_W'(i_req.slot_index);
    assign idx_bad   = (32'(i_req.slot_index) >= 32'(SLOTS));
    assign range_bad = (32'(i_req.range_first) >= 32'(SLOTS))
                    || (32'(i_req.range_limit) > 32'(SLOTS))
                    || (32'(i_req.range_first) > 32'(i_req.range_limit));

    // Search window: the whole table for a plain add, else the given range.
    always_comb begin
        if (i_req.req_type == REQ_ADD_RANGE) begin
            lo = 32'(i_req.range_first);
            hi = 32'(i_req.range_limit);
        end else begin
            lo = '0;
            hi = 32'(SLOTS);
        end
    end

    // Free slots inside the window, and the lowest of them.
    always_comb begin
        found     = '0;
        found_any = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            cand[i] = !r_bitmap[i] && (32'(i) >= lo) && (32'(i) < hi);
        end
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                found     = IDX_W'(i);
                found_any = 1'b1;
            end
        end
    end

    // Request evaluation; bitmap and count are updated at the accept edge.
    always_comb begin
        n_status  = ST_OK;
        n_used    = '0;
        n_was_occ = 1'b0;
        n_we      = 1'b0;
        n_bitmap  = r_bitmap;
        n_count   = r_count;
        case (i_req.req_type)
            REQ_READ: begin
                if (idx_bad) begin
                    n_status = ST_BAD;
                end else begin
                    n_used    = idx;
                    n_was_occ = r_bitmap[idx];
                end
            end
            REQ_WRITE: begin
                if (idx_bad || val_zero) begin
                    n_status = ST_BAD;
                end else begin
                    n_used        = idx;
                    n_was_occ     = r_bitmap[idx];
                    n_we          = 1'b1;
                    n_bitmap[idx] = 1'b1;
                    if (!r_bitmap[idx]) begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            REQ_CLEAR: begin
                if (idx_bad) begin
                    n_status = ST_BAD;
                end else begin
                    n_used        = idx;
                    n_was_occ     = r_bitmap[idx];
                    n_bitmap[idx] = 1'b0;
                    if (r_bitmap[idx]) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            REQ_ADD, REQ_ADD_RANGE: begin
                if (val_zero || ((i_req.req_type == REQ_ADD_RANGE) && range_bad)) begin
                    n_status = ST_BAD;
                end else if (!found_any) begin
                    n_status = ST_NO_FREE;
                end else begin
                    n_used          = found;
                    n_we            = 1'b1;
                    n_bitmap[found] = 1'b1;
                    n_count         = r_count + CNT_W'(1);
                end
            end
            default: begin
                n_status = ST_BAD;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bitmap <= '0;
            r_count  <= '0;
            r_we     <= 1'b0;
        end else if (accept) begin
            r_state  <= S_RESP;
            r_bitmap <= n_bitmap;
            r_count  <= n_count;
            r_we     <= n_we;
        end else begin
            r_state  <= S_IDLE;
            r_we     <= 1'b0;
        end
    end

    // Per-transaction payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= n_status;
            r_used    <= n_used;
            r_was_occ <= n_was_occ;
            r_wdata   <= val;
        end
    end

    // Slot store: read at accept, written in the result cycle.
    stffa_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_we),
        .i_waddr (r_used),
        .i_wdata (r_wdata),
        .i_raddr (n_used),
        .o_rdata (ram_q)
    );

    // Result transaction; an empty slot reads as zero.
    always_comb begin
        o_res.status         = r_status;
        o_res.slot_used      = IDX_F_W'(r_used);
        o_res.read_value     = r_was_occ ? VAL_F_W'(ram_q) : '0;
        o_res.occupied_count = CNT_F_W'(r_count);
    end

    // The count always matches the bitmap.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) == 32'($countones(r_bitmap)))
        else $error("occupied count differs from bitmap");

    // A result comes only in the cycle after an accepted transaction.
    a_done_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy))
        else $error("result without an accepted transaction");

    // The block is busy for a single cycle per transaction.
    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    // A failed request reports no slot and no data.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_res.status != ST_OK)) |->
        ((o_res.slot_used == '0) && (o_res.read_value == '0) && !r_we))
        else $error("failed request carries slot or data");

endmodule

`default_nettype wire

[hw/rtl/stffa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module stffa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the first-fit slot allocator: a queue-fed driver,
// a result monitor and a shadow slot table that predicts every result.
// Depends on stffa_pkg and slot_table_first_free_allocator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stffa_pkg::*;

    localparam int SLOT_COUNT   = SLOTS_DEF;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 40;

    // Request codes the block does not define; all of them must be refused.
    localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = 3'd7;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_res o_res;

    t_req pending_reqs[$];
    t_res expected_res[$];

    // Shadow copy of the slot table and its occupancy count.
    logic [VAL_F_W-1:0] shadow_slots [SLOT_COUNT] = '{default: '0};
    int shadow_count = 0;

    int idle_pct     = 0;
    int gap_left     = 0;
    int stall_cycles = 0;
    int error_count  = 0;

    slot_table_first_free_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_res   (o_res)
    );

    // Clock, 12 ns period.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Lowest empty slot in [first, limit), or limit when there is none.
    function automatic int lowest_free(int first, int limit);
        int i;
        i = first;
        while (i < limit && i < SLOT_COUNT && shadow_slots[i] != '0)
            i++;
        return i;
    endfunction

    // Places a non-zero value and returns what the slot held before.
    function automatic logic [VAL_F_W-1:0] store_slot(int idx, logic [VAL_F_W-1:0] value);
        logic [VAL_F_W-1:0] prior;
        prior = shadow_slots[idx];
        shadow_slots[idx] = value;
        if (prior == '0 && shadow_count < SLOT_COUNT)
            shadow_count++;
        return prior;
    endfunction

    // Applies one request to the shadow table and returns the result it must give.
    function automatic t_res predict_slot_op(t_req r);
        t_res res;
        int   idx;
        int   first;
        int   limit;
        int   pick;
        res   = '0;
        idx   = r.slot_index;
        first = r.range_first;
        limit = r.range_limit;
        res.status = ST_OK;
        case (r.req_type)
            REQ_READ: begin
                res.slot_used  = r.slot_index;
                res.read_value = shadow_slots[idx];
            end
            REQ_WRITE: begin
                if (r.store_value == '0) begin
                    res.status = ST_BAD;
                end else begin
                    res.slot_used  = r.slot_index;
                    res.read_value = store_slot(idx, r.store_value);
                end
            end
            REQ_CLEAR: begin
                res.slot_used  = r.slot_index;
                res.read_value = shadow_slots[idx];
                shadow_slots[idx] = '0;
                if (res.read_value != '0 && shadow_count > 0)
                    shadow_count--;
            end
            REQ_ADD, REQ_ADD_RANGE: begin
                // A plain add searches the whole table.
                if (r.req_type == REQ_ADD) begin
                    first = 0;
                    limit = SLOT_COUNT;
                end
                if (r.store_value == '0 || first >= SLOT_COUNT || limit > SLOT_COUNT
                        || first > limit) begin
                    res.status = ST_BAD;
                end else if (shadow_count >= SLOT_COUNT) begin
                    res.status = ST_NO_FREE;
                end else begin
                    pick = lowest_free(first, limit);
                    if (pick >= limit) begin
                        res.status = ST_NO_FREE;
                    end else begin
                        res.slot_used  = IDX_F_W'(pick);
                        res.read_value = store_slot(pick, r.store_value);
                    end
                end
            end
            default: begin
                res.status = ST_BAD;
            end
        endcase
        res.occupied_count = CNT_F_W'(shadow_count);
        return res;
    endfunction

    function automatic t_req make_req(logic [REQ_W-1:0] kind, int idx,
                                      logic [VAL_F_W-1:0] value, int first, int limit);
        t_req r;
        r.req_type    = kind;
        r.slot_index  = IDX_F_W'(idx);
        r.store_value = value;
        r.range_first = IDX_F_W'(first);
        r.range_limit = LIM_F_W'(limit);
        return r;
    endfunction

    // Random request; weights are percentages, the remainder goes to spare codes.
    function automatic t_req random_req(int w_read, int w_write, int w_clear,
                                        int w_add, int w_range);
        t_req r;
        int   roll;
        int   span;
        r.slot_index  = IDX_F_W'($urandom_range(SLOT_COUNT - 1));
        r.range_first = IDX_F_W'($urandom_range(SLOT_COUNT - 1));
        r.range_limit = LIM_F_W'($urandom_range(127));
        case ($urandom_range(15))
            0:       r.store_value = '0;
            1:       r.store_value = '1;
            default: r.store_value = $urandom;
        endcase
        roll = $urandom_range(99);
        if (roll < w_read)
            r.req_type = REQ_READ;
        else if (roll < w_read + w_write)
            r.req_type = REQ_WRITE;
        else if (roll < w_read + w_write + w_clear)
            r.req_type = REQ_CLEAR;
        else if (roll < w_read + w_write + w_clear + w_add)
            r.req_type = REQ_ADD;
        else if (roll < w_read + w_write + w_clear + w_add + w_range)
            r.req_type = REQ_ADD_RANGE;
        else
            r.req_type = REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
        // Most ranges are well formed, many of them narrow; the rest stay raw.
        if ($urandom_range(4) != 0) begin
            span = SLOT_COUNT - int'(r.range_first);
            if ($urandom_range(1) == 0 && span > 8)
                span = 8;
            r.range_limit = LIM_F_W'(int'(r.range_first) + $urandom_range(span));
        end
        return r;
    endfunction

    task automatic wait_all_done();
        while (pending_reqs.size() != 0 || expected_res.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(int count, int pct, int w_read, int w_write, int w_clear,
                             int w_add, int w_range);
        idle_pct = pct;
        repeat (count)
            pending_reqs.push_back(random_req(w_read, w_write, w_clear, w_add, w_range));
        wait_all_done();
    endtask

    task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
        if (error_count < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        error_count++;
    endtask

    // Driver: presents the oldest pending request and predicts it once accepted.
    always @(posedge i_clk) begin
        logic took;
        took = i_rst_n && start && busy === 1'b0;
        if (took) begin
            expected_res.push_back(predict_slot_op(pending_reqs[0]));
            void'(pending_reqs.pop_front());
        end
        if (gap_left == 0 && (took || !start) && idle_pct > 0
                && $urandom_range(99) < idle_pct)
            gap_left = $urandom_range(1, 13);
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
            start <= 1'b1;
            i_req <= pending_reqs[0];
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: every result transaction is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_res.size() == 0) begin
                report_mismatch("unexpected result", '0, o_res);
            end else begin
                want = expected_res.pop_front();
                if (o_res.status !== want.status)
                    report_mismatch("status", want.status, o_res.status);
                if (o_res.slot_used !== want.slot_used)
                    report_mismatch("slot_used", want.slot_used, o_res.slot_used);
                if (o_res.read_value !== want.read_value)
                    report_mismatch("read_value", want.read_value, o_res.read_value);
                if (o_res.occupied_count !== want.occupied_count)
                    report_mismatch("occupied_count", want.occupied_count,
                                    o_res.occupied_count);
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_done === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("%0t: watchdog expired after %0d idle cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus: directed corner cases, then random phases with a full drain between them.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty and full slots, refused values, odd ranges, spare codes.
        idle_pct = 20;
        pending_reqs.push_back(make_req(REQ_READ,      0,  32'h0,         0,  0));
        pending_reqs.push_back(make_req(REQ_CLEAR,     63, 32'h0,         0,  0));
        pending_reqs.push_back(make_req(REQ_WRITE,     63, 32'hFFFF_FFFF, 0,  0));
        pending_reqs.push_back(make_req(REQ_WRITE,     0,  32'h0,         0,  0));
        pending_reqs.push_back(make_req(REQ_ADD,       5,  32'h1,         0,  0));
        pending_reqs.push_back(make_req(REQ_ADD,       0,  32'h0,         0,  64));
        pending_reqs.push_back(make_req(REQ_WRITE,     63, 32'h5,         0,  0));
        pending_reqs.push_back(make_req(REQ_READ,      63, 32'h0,         0,  0));
        pending_reqs.push_back(make_req(REQ_ADD_RANGE, 0,  32'h77,        10, 10));
        pending_reqs.push_back(make_req(REQ_ADD_RANGE, 0,  32'h77,        63, 64));
        pending_reqs.push_back(make_req(REQ_ADD_RANGE, 0,  32'h77,        0,  65));
        pending_reqs.push_back(make_req(REQ_ADD_RANGE, 0,  32'h77,        20, 10));
        pending_reqs.push_back(make_req(REQ_ADD_RANGE, 0,  32'h0,         0,  127));
        pending_reqs.push_back(make_req(REQ_ADD_RANGE, 0,  32'h8000_0000, 62, 64));
        pending_reqs.push_back(make_req(REQ_ADD_RANGE, 0,  32'hFFFF_FFFF, 0,  64));
        pending_reqs.push_back(make_req(REQ_SPARE_FIRST, 3, 32'h9,        1,  2));
        pending_reqs.push_back(make_req(REQ_SPARE_LAST, 63, 32'hFFFF_FFFF, 63, 127));
        pending_reqs.push_back(make_req(REQ_CLEAR,     0,  32'h0,         0,  0));
        pending_reqs.push_back(make_req(REQ_ADD,       0,  32'h1234,      0,  0));
        pending_reqs.push_back(make_req(REQ_READ,      62, 32'h0,         0,  0));
        pending_reqs.push_back(make_req(REQ_ADD_RANGE, 0,  32'h42,        63, 63));
        pending_reqs.push_back(make_req(REQ_ADD_RANGE, 0,  32'h42,        0,  0));
        wait_all_done();

        // Random part: fill the table past full, empty it, mix, then run without gaps.
        run_phase(300, 25, 10, 15, 5,  40, 25);
        run_phase(300, 15, 15, 5,  60, 10, 5);
        run_phase(350, 35, 20, 15, 20, 20, 20);
        run_phase(400, 0,  15, 15, 15, 25, 25);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

[filelist.f]
hw/rtl/stffa_pkg.sv
hw/rtl/stffa_ram.sv
hw/rtl/slot_table_first_free_allocator.sv
test/testbench.sv
